// ===== hw/rtl/acs_pkg.sv =====
// Package for the AABB collision step block: sequencer states, widths, constants.
// Used by aabb_collision_step, acs_mul and the testbench; depends on nothing.
package acs_pkg;
  localparam int unsigned TimeStepW = 20;
  localparam int unsigned CountW    = 5;
  localparam int unsigned PosW      = 32;
  localparam int unsigned HalfW     = 30;
  localparam int unsigned BoundW    = 34;
  localparam int unsigned ResultCap = 16;
  localparam logic [TimeStepW-1:0] TimeStepReset = 20'd1092;

  localparam logic CfgTimeStep    = 1'b0;
  localparam logic CfgEntityCount = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StIntRd,
    StIntX,
    StIntY,
    StIntWr,
    StPairRd,
    StPairA,
    StPairB,
    StPairChk,
    StPairWrA,
    StPairWrB,
    StEmitRd,
    StEmit
  } state_e;

  typedef enum logic [1:0] {
    SideLeft,
    SideRight,
    SideUp,
    SideDown
  } side_e;
endpackage

// ===== hw/rtl/aabb_collision_step.sv =====
// Top level of the AABB collision step block: entity table, sequencer, datapath.
// Depends on acs_pkg, acs_ram and acs_mul.
//
// Usage. The input channel (in_valid_i / in_stall_o) carries one word per item.
// A load word (mode 0) writes one entity slot at the accepting edge, so loads can
// follow back to back. A step word (mode 1) integrates the first entity_count
// slots (capped at MAX_ENTITIES and 16), checks every ordered pair whose first
// member is not static and pushes their boxes apart, then sends one output word
// per slot on the output channel (out_valid_o / out_stall_i), the last one flagged
// by last_o. A step runs in phases: it integrates and snapshots each entity in turn;
// then, for each non-static first member, it visits every second member, with an
// extra write when the pair overlaps, and skips a static first member; finally it
// emits the output words. A single shared multiplier serves the x and y integration.
// The block takes no input while a step runs. When the receiver stalls, the
// output word holds and the sequencer waits. Reset clears the sequencer and the
// configuration registers (time_step = 1092, count 0); the entity table is
// undefined until loaded, and no clearing pass runs. Configuration is written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must do this only while
// idle, as the block does not enforce it.
module aabb_collision_step #(
  parameter int unsigned MAX_ENTITIES = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [acs_pkg::TimeStepW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [3:0]                       entity_index_i,
  input  logic signed [31:0]               pos_x_i,
  input  logic signed [31:0]               pos_y_i,
  input  logic signed [31:0]               vel_x_i,
  input  logic signed [31:0]               vel_y_i,
  input  logic [29:0]                      half_width_i,
  input  logic [29:0]                      half_height_i,
  input  logic                             is_static_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       out_index_o,
  output logic signed [31:0]               out_pos_x_o,
  output logic signed [31:0]               out_pos_y_o,
  output logic                             last_o
);
  import acs_pkg::*;

  localparam int unsigned IdxW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int unsigned CapN = (MAX_ENTITIES < ResultCap) ? MAX_ENTITIES : ResultCap;
  localparam int unsigned RecW = 2 * PosW + 2 * HalfW + 1;
  localparam int unsigned BoxW = 4 * BoundW;

  state_e state_q, state_d;

  logic [TimeStepW-1:0] dt_q;
  logic [CountW-1:0]    cnt_q;
  logic [CountW-1:0]    n_q;
  logic [CountW-1:0]    n_cap;
  logic [IdxW-1:0]      a_q, a_d, b_q, b_d;

  // The count taken by a step, capped at the table size and the result limit.
  assign n_cap = (cnt_q > CountW'(CapN)) ? CountW'(CapN) : cnt_q;

  // Entity table: position in one RAM, constants (vel, half extents, static) in another.
  logic            pos_we;
  logic [IdxW-1:0] pos_waddr, pos_raddr;
  logic [2*PosW-1:0] pos_wdata, pos_rdata;
  logic            rec_we;
  logic [IdxW-1:0] rec_raddr;
  logic [RecW-1:0] rec_wdata, rec_rdata;
  logic            box_we;
  logic [IdxW-1:0] box_raddr;
  logic [BoxW-1:0] box_wdata, box_rdata;
  logic [IdxW-1:0] load_idx;

  assign load_idx = IdxW'(entity_index_i);

  acs_ram #(.Width(2 * PosW), .Depth(MAX_ENTITIES)) u_pos_ram (
    .clk_i, .we_i(pos_we), .waddr_i(pos_waddr), .wdata_i(pos_wdata),
    .raddr_i(pos_raddr), .rdata_o(pos_rdata)
  );
  acs_ram #(.Width(RecW), .Depth(MAX_ENTITIES)) u_rec_ram (
    .clk_i, .we_i(rec_we), .waddr_i(load_idx), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );
  acs_ram #(.Width(BoxW), .Depth(MAX_ENTITIES)) u_box_ram (
    .clk_i, .we_i(box_we), .waddr_i(a_q), .wdata_i(box_wdata),
    .raddr_i(box_raddr), .rdata_o(box_rdata)
  );

  logic in_fire, load_ok;
  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  // Every 4-bit slot number is valid once the table holds at least 16 entries.
  assign load_ok    = (MAX_ENTITIES > 15) || (entity_index_i < 4'(MAX_ENTITIES));
  assign rec_we     = in_fire && !mode_i && load_ok;
  assign rec_wdata  = {vel_x_i, vel_y_i, half_width_i, half_height_i, is_static_i};

  // Record of a (or the integrated entity) and of b.
  logic [PosW-1:0]  ax_q, ay_q, bx_q, by_q, vy_q;
  logic [HalfW-1:0] ahx_q, ahy_q, bhx_q, bhy_q;
  logic             bst_q;
  logic [BoxW-1:0]  abox_q;
  logic [PosW-1:0]  ax_d, ay_d, bx_d, by_d;

  // Shared multiplier, fed with vx straight from the table, then with vy.
  logic [PosW-1:0] mul_vel, delta;
  assign mul_vel = (state_q == StIntX) ? rec_rdata[RecW-1 -: PosW] : vy_q;
  acs_mul u_mul (.clk_i, .vel_i(mul_vel), .dt_i(dt_q), .delta_o(delta));

  // Integrated y and the snapshot box of the entity being integrated.
  logic [PosW-1:0]          iy;
  logic signed [BoundW-1:0] cx, cy, hxe, hye;
  assign iy  = ay_q + delta;
  assign cx  = BoundW'($signed(ax_q));
  assign cy  = BoundW'($signed(iy));
  assign hxe = BoundW'(ahx_q);
  assign hye = BoundW'(ahy_q);

  // Pair datapath, evaluated from registered operands.
  logic signed [BoundW-1:0] aminx, amaxx, aminy, amaxy, bminx, bmaxx, bminy, bmaxy;
  logic signed [BoundW-1:0] left, right, up, down, best;
  logic signed [PosW:0]     nx, ny, anx, any_abs;
  logic signed [PosW+1:0]   xp, yp;
  logic overlap;
  side_e side;
  logic [PosW-1:0] pen;

  always_comb begin
    {aminx, amaxx, aminy, amaxy} = abox_q;
    {bminx, bmaxx, bminy, bmaxy} = box_rdata;
    overlap = !(amaxx < bminx || amaxy < bminy || aminx > bmaxx || aminy > bmaxy);
    nx = $signed({ax_q[PosW-1], ax_q}) - $signed({bx_q[PosW-1], bx_q});
    ny = $signed({ay_q[PosW-1], ay_q}) - $signed({by_q[PosW-1], by_q});
    anx = nx[PosW] ? -nx : nx;
    any_abs = ny[PosW] ? -ny : ny;
    xp = $signed({2'b0, ahx_q}) + $signed({2'b0, bhx_q}) - $signed({anx[PosW], anx});
    yp = $signed({2'b0, ahy_q}) + $signed({2'b0, bhy_q}) - $signed({any_abs[PosW], any_abs});
    left = amaxx - bminx;
    right = bmaxx - aminx;
    up = amaxy - bminy;
    down = bmaxy - aminy;
    side = SideLeft;
    best = left;
    if (right < best) begin
      best = right;
      side = SideRight;
    end
    if (up < best) begin
      best = up;
      side = SideUp;
    end
    if (down < best) begin
      side = SideDown;
    end
    pen = (side == SideLeft || side == SideRight) ? xp[PosW-1:0] : yp[PosW-1:0];
    ax_d = ax_q;
    ay_d = ay_q;
    bx_d = bx_q;
    by_d = by_q;
    case (side)
      SideLeft: begin
        ax_d = ax_q - pen;
        bx_d = bx_q + pen;
      end
      SideRight: begin
        ax_d = ax_q + pen;
        bx_d = bx_q - pen;
      end
      SideUp: begin
        ay_d = ay_q - pen;
        by_d = by_q + pen;
      end
      default: begin
        ay_d = ay_q + pen;
        by_d = by_q - pen;
      end
    endcase
  end

  logic [IdxW-1:0] last_idx;
  logic b_last, a_last, a_static;
  assign last_idx = IdxW'(n_q - 5'd1);
  assign a_last   = (a_q == last_idx);
  assign b_last   = (b_q == last_idx);
  assign a_static = rec_rdata[0];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_fire && mode_i) state_d = (n_cap == '0) ? StIdle : StIntRd;
      StIntRd:   state_d = StIntX;
      StIntX:    state_d = StIntY;
      StIntY:    state_d = StIntWr;
      StIntWr:   state_d = a_last ? StPairRd : StIntRd;
      StPairRd:  state_d = StPairA;
      StPairA:   begin
        if (a_static) state_d = a_last ? StEmitRd : StPairRd;
        else          state_d = StPairB;
      end
      StPairB:   state_d = StPairChk;
      StPairChk: begin
        if (a_q != b_q && overlap) state_d = StPairWrA;
        else if (!b_last)          state_d = StPairB;
        else                       state_d = StPairWrB;
      end
      StPairWrA: state_d = b_last ? StPairWrB : StPairB;
      StPairWrB: state_d = a_last ? StEmitRd : StPairRd;
      StEmitRd:  state_d = StEmit;
      StEmit:    if (!out_stall_i) state_d = b_last ? StIdle : StEmitRd;
      default:   state_d = StIdle;
    endcase
  end

  // Index counters and RAM control.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    pos_we = 1'b0;
    pos_waddr = a_q;
    pos_wdata = {ax_q, ay_q};
    pos_raddr = a_q;
    rec_raddr = a_q;
    box_raddr = b_q;
    box_we = 1'b0;
    box_wdata = '0;
    if (rec_we) begin
      pos_we = 1'b1;
      pos_waddr = load_idx;
      pos_wdata = {pos_x_i, pos_y_i};
    end
    case (state_q)
      StIdle: begin
        a_d = '0;
        b_d = '0;
      end
      StIntWr: begin
        pos_we = 1'b1;
        pos_wdata = {ax_q, iy};
        box_we = 1'b1;
        box_wdata = {cx - hxe, cx + hxe, cy - hye, cy + hye};
        a_d = a_last ? '0 : a_q + 1'b1;
      end
      StPairRd: box_raddr = a_q;
      StPairA: begin
        b_d = '0;
        if (a_static) a_d = a_last ? '0 : a_q + 1'b1;
      end
      StPairB: begin
        pos_raddr = b_q;
        rec_raddr = b_q;
      end
      StPairChk: begin
        if (!(a_q != b_q && overlap)) b_d = b_q + 1'b1;
      end
      StPairWrA: begin
        if (!bst_q) begin
          pos_we = 1'b1;
          pos_waddr = b_q;
          pos_wdata = {bx_d, by_d};
        end
        b_d = b_q + 1'b1;
      end
      StPairWrB: begin
        pos_we = 1'b1;
        pos_waddr = a_q;
        pos_wdata = {ax_q, ay_q};
        a_d = a_last ? '0 : a_q + 1'b1;
        b_d = '0;
      end
      StEmitRd: pos_raddr = b_q;
      StEmit: begin
        // Keep reading the same slot so a stalled word holds its value.
        pos_raddr = b_q;
        if (!out_stall_i) b_d = b_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIntX: begin
        {ax_q, ay_q} <= pos_rdata;
        {vy_q, ahx_q, ahy_q} <= rec_rdata[RecW-PosW-1:1];
      end
      StIntY: begin
        ax_q <= ax_q + delta;
      end
      StIntWr: ;
      StPairA: begin
        {ax_q, ay_q} <= pos_rdata;
        {ahx_q, ahy_q} <= rec_rdata[2*HalfW:1];
        abox_q <= box_rdata;
      end
      StPairB: ;
      StPairChk: begin
        {bx_q, by_q} <= pos_rdata;
        {bhx_q, bhy_q} <= rec_rdata[2*HalfW:1];
        bst_q <= rec_rdata[0];
      end
      StPairWrA: begin
        ax_q <= ax_d;
        ay_q <= ay_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dt_q <= TimeStepReset;
      cnt_q <= '0;
      n_q <= '0;
      a_q <= '0;
      b_q <= '0;
    end else begin
      state_q <= state_d;
      a_q <= a_d;
      b_q <= b_d;
      if (cfg_we_i && cfg_index_i == CfgTimeStep) dt_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == CfgEntityCount) cnt_q <= cfg_data_i[CountW-1:0];
      if (in_fire && mode_i)
        n_q <= n_cap;
    end
  end

  assign out_valid_o = (state_q == StEmit);
  assign out_index_o = 4'(b_q);
  assign {out_pos_x_o, out_pos_y_o} = pos_rdata;
  assign last_o = b_last;
endmodule

// ===== hw/rtl/acs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module acs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/acs_mul.sv =====
// Shared 32x20 signed-by-unsigned multiplier with a registered product and floor shift.
// Depends on acs_pkg.
module acs_mul (
  input  logic                            clk_i,
  input  logic [acs_pkg::PosW-1:0]        vel_i,
  input  logic [acs_pkg::TimeStepW-1:0]   dt_i,
  output logic [acs_pkg::PosW-1:0]        delta_o
);
  import acs_pkg::*;
  logic signed [PosW+TimeStepW:0] prod_q;

  // An arithmetic shift of the product is floor division by 2^16.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(vel_i) * $signed({1'b0, dt_i});
  end

  assign delta_o = prod_q[PosW+15:16];
endmodule

// ===== hw/rtl/acs_checker.sv =====
// Port-level checker for aabb_collision_step, attached by bind.
// Depends on acs_pkg only through the bound design.
module acs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       last_o,
  input logic [3:0] out_index_o
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during output");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_index_o))
    else $error("output word changed under stall");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("output after last");
endmodule

bind aabb_collision_step acs_checker u_acs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .last_o, .out_index_o
);

// ===== tb/sv/tb_aabb_collision_step.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for aabb_collision_step: entity loads, physics steps and
// per-entity position words checked against an in-bench predictor. Depends on acs_pkg.
module tb_aabb_collision_step;
  import acs_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeStep = 1'b1;
  localparam int unsigned RandomItems = 360;
  // Settle time after the last expected word before the block counts as idle.
  localparam int unsigned SettleCycles = 40;

  typedef struct {
    logic        mode;
    logic [3:0]  slot;
    logic [31:0] px, py, vx, vy;
    logic [29:0] hw, hh;
    logic        stat;
  } body_word_t;

  typedef struct {
    logic [3:0]  slot;
    logic [31:0] x, y;
    logic        last;
  } pos_word_t;

  typedef struct {
    bit          do_cfg;
    logic [19:0] cfg_dt;
    logic [4:0]  cfg_cnt;
    body_word_t  item;
    bit          typed;
    logic [31:0] typed_x, typed_y;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_index_i;
  logic [TimeStepW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic mode_i, is_static_i;
  logic [3:0] entity_index_i;
  logic signed [31:0] pos_x_i, pos_y_i, vel_x_i, vel_y_i;
  logic [29:0] half_width_i, half_height_i;
  logic out_valid_o, out_stall_i;
  logic [3:0] out_index_o;
  logic signed [31:0] out_pos_x_o, out_pos_y_o;
  logic last_o;

  aabb_collision_step i_dut (.*);

  // Predictor copy of the registers and the entity table.
  logic [19:0] dt_q;
  logic [4:0]  count_q;
  logic [31:0] tbl_px[NumSlots], tbl_py[NumSlots], tbl_vx[NumSlots], tbl_vy[NumSlots];
  logic [29:0] tbl_hw[NumSlots], tbl_hh[NumSlots];
  logic        tbl_stat[NumSlots];

  pos_word_t   expected_positions[$];
  stim_row_t   stim_table[$];
  int unsigned mismatches, words_seen, steps_sent, items_sent;
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d words still expected.", expected_positions.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One physics tick over the first count slots (at most NumSlots), appending one word per slot.
  function automatic void predict_tick(output pos_word_t words[$]);
    int unsigned n;
    longint lo_x[NumSlots], hi_x[NumSlots], lo_y[NumSlots], hi_y[NumSlots];
    longint nx, ny, xp, yp, best;
    longint cand[4];
    side_e side;
    pos_word_t w;
    words = {};
    n = (count_q > NumSlots) ? NumSlots : count_q;
    for (int i = 0; i < n; i++) begin
      // An arithmetic shift of the product is the floor division by 2^16.
      tbl_px[i] = tbl_px[i] + 32'((longint'($signed(tbl_vx[i])) * longint'(dt_q)) >>> 16);
      tbl_py[i] = tbl_py[i] + 32'((longint'($signed(tbl_vy[i])) * longint'(dt_q)) >>> 16);
    end
    for (int i = 0; i < n; i++) begin
      lo_x[i] = longint'($signed(tbl_px[i])) - longint'(tbl_hw[i]);
      hi_x[i] = longint'($signed(tbl_px[i])) + longint'(tbl_hw[i]);
      lo_y[i] = longint'($signed(tbl_py[i])) - longint'(tbl_hh[i]);
      hi_y[i] = longint'($signed(tbl_py[i])) + longint'(tbl_hh[i]);
    end
    for (int a = 0; a < n; a++) begin
      if (tbl_stat[a]) continue;
      for (int b = 0; b < n; b++) begin
        if (a == b) continue;
        if (hi_x[a] < lo_x[b] || hi_y[a] < lo_y[b] || lo_x[a] > hi_x[b] || lo_y[a] > hi_y[b])
          continue;
        // Penetration uses the live centres, which earlier pairs may have moved.
        nx = longint'($signed(tbl_px[a])) - longint'($signed(tbl_px[b]));
        ny = longint'($signed(tbl_py[a])) - longint'($signed(tbl_py[b]));
        xp = longint'(tbl_hw[a]) + longint'(tbl_hw[b]) - (nx < 0 ? -nx : nx);
        yp = longint'(tbl_hh[a]) + longint'(tbl_hh[b]) - (ny < 0 ? -ny : ny);
        cand[0] = hi_x[a] - lo_x[b];
        cand[1] = hi_x[b] - lo_x[a];
        cand[2] = hi_y[a] - lo_y[b];
        cand[3] = hi_y[b] - lo_y[a];
        side = SideLeft;
        best = cand[0];
        if (cand[1] < best) begin best = cand[1]; side = SideRight; end
        if (cand[2] < best) begin best = cand[2]; side = SideUp; end
        if (cand[3] < best) begin best = cand[3]; side = SideDown; end
        case (side)
          SideLeft: begin
            tbl_px[a] = tbl_px[a] - 32'(xp);
            if (!tbl_stat[b]) tbl_px[b] = tbl_px[b] + 32'(xp);
          end
          SideRight: begin
            tbl_px[a] = tbl_px[a] + 32'(xp);
            if (!tbl_stat[b]) tbl_px[b] = tbl_px[b] - 32'(xp);
          end
          SideUp: begin
            tbl_py[a] = tbl_py[a] - 32'(yp);
            if (!tbl_stat[b]) tbl_py[b] = tbl_py[b] + 32'(yp);
          end
          default: begin
            tbl_py[a] = tbl_py[a] + 32'(yp);
            if (!tbl_stat[b]) tbl_py[b] = tbl_py[b] - 32'(yp);
          end
        endcase
      end
    end
    for (int i = 0; i < n; i++) begin
      w.slot = 4'(i);
      w.x = tbl_px[i];
      w.y = tbl_py[i];
      w.last = (i + 1 == n);
      words.insert(words.size(), w);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Clustered boxes collide often; a small share of loads carry raw noise.
  function automatic body_word_t make_load(logic [3:0] slot, bit noisy);
    body_word_t b;
    b.mode = ModeLoad;
    b.slot = slot;
    if (noisy) begin
      b.px = $urandom; b.py = $urandom; b.vx = $urandom; b.vy = $urandom;
      b.hw = 30'($urandom); b.hh = 30'($urandom);
    end else begin
      b.px = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      b.py = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      b.vx = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      b.vy = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      b.hw = 30'($urandom_range(0, 3 << 16));
      b.hh = 30'($urandom_range(0, 3 << 16));
    end
    b.stat = ($urandom_range(0, 3) == 0);
    return b;
  endfunction

  // Wait until every word has arrived and the block has settled, then write.
  task automatic write_cfg(logic [19:0] dt, logic [4:0] cnt);
    in_valid_i <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgTimeStep;
    cfg_data_i  <= dt;
    @(posedge clk_i);
    cfg_index_i <= CfgEntityCount;
    // Upper data bits are junk; only the low five bits belong to the count.
    cfg_data_i  <= {15'($urandom), cnt};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dt_q    = dt;
    count_q = cnt;
  endtask

  // Present one word; valid is left high on return so a follow-on word
  // can be driven without a gap in the same time step.
  task automatic send_word(body_word_t b, bit typed, logic [31:0] tx, logic [31:0] ty);
    int unsigned gap;
    pos_word_t words[$];
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i <= b.mode; entity_index_i <= b.slot;
    pos_x_i <= b.px; pos_y_i <= b.py; vel_x_i <= b.vx; vel_y_i <= b.vy;
    half_width_i <= b.hw; half_height_i <= b.hh; is_static_i <= b.stat;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (b.mode == ModeLoad) begin
      tbl_px[b.slot] = b.px; tbl_py[b.slot] = b.py;
      tbl_vx[b.slot] = b.vx; tbl_vy[b.slot] = b.vy;
      tbl_hw[b.slot] = b.hw; tbl_hh[b.slot] = b.hh;
      tbl_stat[b.slot] = b.stat;
    end else begin
      steps_sent++;
      predict_tick(words);
      if (typed) begin
        words[0].x = tx;
        words[0].y = ty;
      end
      foreach (words[k]) expected_positions.insert(expected_positions.size(), words[k]);
    end
  endtask

  // Receiver: random stall bursts, and the check of every accepted word.
  int unsigned stall_hold;
  always @(posedge clk_i or negedge rst_ni) begin
    pos_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_hold  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (expected_positions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected word: slot %0d x %h y %h", out_index_o, out_pos_x_o,
                     out_pos_y_o);
        end else begin
          want = expected_positions.pop_front();
          if (out_index_o !== want.slot || out_pos_x_o !== want.x ||
              out_pos_y_o !== want.y || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Word mismatch: want slot %0d x %h y %h last %b, got %0d %h %h %b",
                       want.slot, want.x, want.y, want.last,
                       out_index_o, out_pos_x_o, out_pos_y_o, last_o);
          end
        end
      end
      if (stall_hold != 0) begin
        stall_hold--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
        stall_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 2);
      end
    end
  end

  function automatic stim_row_t plain_row(body_word_t b);
    stim_row_t r;
    r.do_cfg = 1'b0; r.cfg_dt = '0; r.cfg_cnt = '0;
    r.item = b; r.typed = 1'b0; r.typed_x = '0; r.typed_y = '0;
    return r;
  endfunction

  function automatic stim_row_t step_row(bit do_cfg, logic [19:0] dt, logic [4:0] cnt);
    stim_row_t r;
    body_word_t b;
    b = make_load(4'd0, 1'b1);
    b.mode = ModeStep;
    r = plain_row(b);
    r.do_cfg = do_cfg; r.cfg_dt = dt; r.cfg_cnt = cnt;
    return r;
  endfunction

  initial begin
    body_word_t b;
    stim_row_t r;
    int unsigned cnt_pick;
    logic [19:0] dt_pick;

    cfg_we_i = 1'b0; cfg_index_i = CfgTimeStep; cfg_data_i = '0;
    in_valid_i = 1'b0; mode_i = ModeLoad; entity_index_i = '0;
    pos_x_i = '0; pos_y_i = '0; vel_x_i = '0; vel_y_i = '0;
    half_width_i = '0; half_height_i = '0; is_static_i = 1'b0;
    dt_q = TimeStepReset; count_q = '0;
    mismatches = 0; words_seen = 0; steps_sent = 0; items_sent = 0;
    calm = 1'b0;

    // Directed table. A step right after reset has zero entities and must stay
    // silent; it runs before any slot is loaded.
    stim_table.insert(stim_table.size(), step_row(1'b0, '0, '0));
    for (int s = 0; s < NumSlots; s++)
      stim_table.insert(stim_table.size(), plain_row(make_load(4'(s), 1'b0)));
    // Slot 0 sits at the most positive x and most negative y and moves at full speed.
    stim_table[1].item.px = 32'h7FFF_FFFF; stim_table[1].item.py = 32'h8000_0000;
    stim_table[1].item.vx = 32'h7FFF_FFFF; stim_table[1].item.vy = 32'h8000_0000;
    stim_table[1].item.hw = 30'h3FFF_FFFF; stim_table[1].item.hh = '0;
    stim_table[1].item.stat = 1'b0;
    // Slot 1 is static and near the other wrap corner.
    stim_table[2].item.px = 32'h8000_0000; stim_table[2].item.py = 32'h7FFF_FFFF;
    stim_table[2].item.vx = 32'h8000_0000; stim_table[2].item.vy = 32'h7FFF_FFFF;
    stim_table[2].item.hw = '0; stim_table[2].item.hh = 30'h3FFF_FFFF;
    stim_table[2].item.stat = 1'b1;
    // Slots 2 and 3 coincide exactly, so left ties right and up ties down; the first side of each tie wins.
    stim_table[3].item = make_load(4'd2, 1'b0);
    stim_table[3].item.vx = '0; stim_table[3].item.vy = '0; stim_table[3].item.stat = 1'b0;
    stim_table[4].item = stim_table[3].item;
    stim_table[4].item.slot = 4'd3;
    // With a zero time step a lone entity comes back exactly where it was loaded.
    r = step_row(1'b1, '0, 5'd1);
    r.typed = 1'b1; r.typed_x = 32'h7FFF_FFFF; r.typed_y = 32'h8000_0000;
    stim_table.insert(stim_table.size(), r);
    stim_table.insert(stim_table.size(), step_row(1'b1, 20'hFFFFF, 5'd16));
    stim_table.insert(stim_table.size(), step_row(1'b1, TimeStepReset, 5'd31));
    stim_table.insert(stim_table.size(), step_row(1'b1, TimeStepReset, 5'd4));
    stim_table.insert(stim_table.size(), step_row(1'b1, 20'd65536, 5'd2));

    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].do_cfg) write_cfg(stim_table[i].cfg_dt, stim_table[i].cfg_cnt);
      send_word(stim_table[i].item, stim_table[i].typed,
                stim_table[i].typed_x, stim_table[i].typed_y);
    end

    // Random phases: retune the registers now and then, then reload a few slots
    // and run a step. Entity counts stay small most of the time.
    for (int n = 0; n < RandomItems; ) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 4))
          0: dt_pick = '0;
          1: dt_pick = 20'hFFFFF;
          2: dt_pick = 20'($urandom);
          default: dt_pick = 20'($urandom_range(500, 8000));
        endcase
        case ($urandom_range(0, 19))
          0: cnt_pick = 0;
          1: cnt_pick = $urandom_range(16, 31);
          default: cnt_pick = $urandom_range(2, 6);
        endcase
        write_cfg(dt_pick, 5'(cnt_pick));
      end
      repeat ($urandom_range(0, 3)) begin
        b = make_load(4'($urandom_range(0, (count_q > 1 && count_q <= 16) ? count_q - 1 : 15)),
                      $urandom_range(0, 9) == 0);
        send_word(b, 1'b0, '0, '0);
        n++;
      end
      b = make_load(4'($urandom), 1'b1);
      b.mode = ModeStep;
      send_word(b, 1'b0, '0, '0);
      n++;
    end

    in_valid_i <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d words including %0d steps; checked %0d position words.",
             items_sent, steps_sent, words_seen);
    $display("Mismatching or unexpected words: %0d.", mismatches);
    if (mismatches == 0 && expected_positions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
